/* design/frt_pkg.sv */
`timescale 1ns / 1ps

package frt_pkg;

  // Result codes reported on out_status.
  typedef enum logic [3:0] {
    ST_STORED        = 4'd0,
    ST_COMPLETE      = 4'd1,
    ST_BAD_LENGTH    = 4'd2,
    ST_OUT_OF_WINDOW = 4'd3,
    ST_REPLAY        = 4'd4,
    ST_DUPLICATE     = 4'd5,
    ST_BAD_INDEX     = 4'd6,
    ST_SIZE_MISMATCH = 4'd7,
    ST_OVERSIZE      = 4'd8
  } frt_status_t;

  typedef enum logic [2:0] {
    FS_CLEAR,
    FS_IDLE,
    FS_CHECK,
    FS_SCAN,
    FS_LOAD,
    FS_EVAL,
    FS_FIN
  } frt_state_t;

  // Verdict of the anti-replay window on the held fragment.
  typedef struct packed {
    logic out_of_window;
    logic replay;
  } frt_win_t;

  localparam int ID_W    = 32;
  localparam int SIZE_W  = 16;
  localparam int STAMP_W = 32;
  localparam int IDX_W   = 8;
  localparam int FSLOT_W = 5;
  localparam logic [STAMP_W-1:0] NO_STAMP = 32'hffffffff;

endpackage

/* design/fragment_reassembly_tracker.sv */
`timescale 1ns / 1ps

// Fragment reassembly tracker with an anti-replay window.
// Input channel (in_valid/in_ready): one fragment header per transaction.
// Output channel (out_valid/out_ready): exactly one result transaction per
// accepted header, in order, giving a status, the collector slot and, on
// completion, the packet id, size and fragment count.
// One fragment is handled at a time. After acceptance the header is checked
// against the frame length and the window, then every slot record is read
// from the slot memory over its single read port, the chosen record is read
// back, updated and written, and the result is registered.
// Bad length, window and replay rejects skip the slot scan and go straight
// to the result.
// After reset the slot memory is swept to zero, one slot per cycle; in_ready
// stays low during that sweep.
// A stalled receiver holds the result in the output register; the next
// header may be accepted and worked on meanwhile, and it waits at its last
// step until the output register is free.
module fragment_reassembly_tracker #(
  parameter int NUM_SLOTS  = 128,
  parameter int MAX_FRAGS  = 32,
  parameter int FRAG_BYTES = 1024,
  parameter int WINDOW     = 5
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_length_ok,
  input  logic [frt_pkg::ID_W-1:0]               in_packet_id,
  input  logic [frt_pkg::IDX_W-1:0]              in_fragment_index,
  input  logic [frt_pkg::SIZE_W-1:0]             in_declared_size,
  input  logic [frt_pkg::STAMP_W-1:0]            in_time_now,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [3:0]                             out_status,
  output logic [$clog2(NUM_SLOTS)-1:0]           out_slot,
  output logic [frt_pkg::FSLOT_W-1:0]            out_fragment_slot,
  output logic [frt_pkg::ID_W-1:0]               out_done_id,
  output logic [frt_pkg::SIZE_W-1:0]             out_done_size,
  output logic [$clog2(MAX_FRAGS + 1)-1:0]       out_done_fragments
);
  import frt_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int TOT_W  = $clog2(MAX_FRAGS + 1);
  // Record layout: busy, id, size, total, count, seen bitmap, stamp.
  localparam int REC_W  = 1 + ID_W + SIZE_W + 2 * TOT_W + MAX_FRAGS + STAMP_W;

  frt_state_t state_r, state_nxt;

  // Held fragment header.
  logic              len_r;
  logic [ID_W-1:0]   id_r;
  logic [IDX_W-1:0]  idx_r;
  logic [SIZE_W-1:0] size_r;
  logic [STAMP_W-1:0] now_r;

  // Scan bookkeeping.
  logic [SLOT_W:0]    cnt_r, cnt_nxt;
  logic               rv_r, rv_nxt;
  logic [SLOT_W-1:0]  ra_r, ra_nxt;
  logic               found_r, found_nxt, free_found_r, free_found_nxt;
  logic [SLOT_W-1:0]  match_r, match_nxt, free_r, free_nxt, best_r, best_nxt;
  logic [STAMP_W-1:0] best_stamp_r, best_stamp_nxt;

  // Pending result.
  logic [3:0]         rs_status_r, rs_status_nxt;
  logic [SLOT_W-1:0]  rs_slot_r, rs_slot_nxt;
  logic [FSLOT_W-1:0] rs_frag_r, rs_frag_nxt;
  logic [ID_W-1:0]    rs_id_r, rs_id_nxt;
  logic [SIZE_W-1:0]  rs_size_r, rs_size_nxt;
  logic [TOT_W-1:0]   rs_frags_r, rs_frags_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [3:0]         o_status_r;
  logic [SLOT_W-1:0]  o_slot_r;
  logic [FSLOT_W-1:0] o_frag_r;
  logic [ID_W-1:0]    o_id_r;
  logic [SIZE_W-1:0]  o_size_r;
  logic [TOT_W-1:0]   o_frags_r;
  logic               load_out;

  // Slot memory ports.
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr, mem_raddr;
  logic [REC_W-1:0]  mem_wdata, mem_rdata;

  frt_win_t verdict;
  logic     win_complete;

  // Unpacked record fields.
  logic                 rd_busy;
  logic [ID_W-1:0]      rd_id;
  logic [SIZE_W-1:0]    rd_size;
  logic [TOT_W-1:0]     rd_total, rd_count;
  logic [MAX_FRAGS-1:0] rd_seen;
  logic [STAMP_W-1:0]   rd_stamp;

  // Evaluation of the chosen slot.
  logic [SLOT_W-1:0]    chosen;
  logic                 is_new;
  logic [SIZE_W:0]      tot_full;
  logic [TOT_W-1:0]     e_total, e_count, cnt_inc;
  logic [SIZE_W-1:0]    e_size;
  logic [MAX_FRAGS-1:0] e_seen, frag_bit;
  logic [STAMP_W-1:0]   e_stamp;
  logic                 in_bitmap;

  frt_slot_mem #(
    .DEPTH(NUM_SLOTS),
    .WIDTH(REC_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  frt_window #(
    .WINDOW(WINDOW)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .id      (id_r),
    .complete(win_complete),
    .verdict (verdict)
  );

  assign {rd_busy, rd_id, rd_size, rd_total, rd_count, rd_seen, rd_stamp} = mem_rdata;

  assign in_ready = (state_r == FS_IDLE);
  assign load_out = (state_r == FS_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    chosen   = found_r ? match_r : (free_found_r ? free_r : best_r);
    is_new   = !found_r;
    // Fragment count of a new packet: size rounded up to whole fragments.
    tot_full = (SIZE_W + 1)'(size_r / FRAG_BYTES) +
               (SIZE_W + 1)'((size_r % FRAG_BYTES) != 0);
    e_total  = is_new ? TOT_W'(tot_full) : rd_total;
    e_size   = is_new ? size_r : rd_size;
    e_count  = is_new ? '0 : rd_count;
    e_seen   = is_new ? '0 : rd_seen;
    e_stamp  = is_new ? '0 : rd_stamp;
    frag_bit = MAX_FRAGS'(1) << idx_r;
    in_bitmap = 16'(idx_r) < 16'(MAX_FRAGS);
    cnt_inc  = e_count + TOT_W'(1);
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rv_nxt         = 1'b0;
    ra_nxt         = ra_r;
    found_nxt      = found_r;
    free_found_nxt = free_found_r;
    match_nxt      = match_r;
    free_nxt       = free_r;
    best_nxt       = best_r;
    best_stamp_nxt = best_stamp_r;
    rs_status_nxt  = rs_status_r;
    rs_slot_nxt    = rs_slot_r;
    rs_frag_nxt    = rs_frag_r;
    rs_id_nxt      = rs_id_r;
    rs_size_nxt    = rs_size_r;
    rs_frags_nxt   = rs_frags_r;
    mem_we         = 1'b0;
    mem_waddr      = chosen;
    mem_wdata      = '0;
    mem_raddr      = cnt_r[SLOT_W-1:0];
    win_complete   = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;

    case (state_r)
      FS_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[SLOT_W-1:0];
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == (SLOT_W + 1)'(NUM_SLOTS - 1)) begin
          state_nxt = FS_IDLE;
        end
      end
      FS_IDLE: begin
        if (in_valid) begin
          state_nxt = FS_CHECK;
        end
      end
      FS_CHECK: begin
        rs_status_nxt = ST_BAD_LENGTH;
        rs_slot_nxt   = '0;
        rs_frag_nxt   = '0;
        rs_id_nxt     = '0;
        rs_size_nxt   = '0;
        rs_frags_nxt  = '0;
        if (!len_r) begin
          state_nxt = FS_FIN;
        end else if (verdict.out_of_window) begin
          rs_status_nxt = ST_OUT_OF_WINDOW;
          state_nxt     = FS_FIN;
        end else if (verdict.replay) begin
          rs_status_nxt = ST_REPLAY;
          state_nxt     = FS_FIN;
        end else begin
          cnt_nxt        = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          best_nxt       = '0;
          best_stamp_nxt = NO_STAMP;
          state_nxt      = FS_SCAN;
        end
      end
      FS_SCAN: begin
        // One read issued per cycle; its record is examined in the cycle after.
        if (cnt_r < (SLOT_W + 1)'(NUM_SLOTS)) begin
          rv_nxt  = 1'b1;
          ra_nxt  = cnt_r[SLOT_W-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end
        if (rv_r) begin
          if (rd_busy && rd_id == id_r && !found_r) begin
            found_nxt = 1'b1;
            match_nxt = ra_r;
          end
          if (!rd_busy && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_nxt       = ra_r;
          end
          if (rd_stamp < best_stamp_r) begin
            best_stamp_nxt = rd_stamp;
            best_nxt       = ra_r;
          end
        end else if (cnt_r == (SLOT_W + 1)'(NUM_SLOTS)) begin
          state_nxt = FS_LOAD;
        end
      end
      FS_LOAD: begin
        mem_raddr = chosen;
        state_nxt = FS_EVAL;
      end
      FS_EVAL: begin
        mem_we        = 1'b1;
        mem_wdata     = {1'b1, id_r, e_size, e_total, e_count, e_seen, e_stamp};
        rs_slot_nxt   = chosen;
        state_nxt     = FS_FIN;
        if (is_new && tot_full > (SIZE_W + 1)'(MAX_FRAGS)) begin
          // The slot is not opened; an evicted slot stays cleared.
          mem_wdata     = '0;
          rs_status_nxt = ST_OVERSIZE;
        end else if (in_bitmap && |(e_seen & frag_bit)) begin
          rs_status_nxt = ST_DUPLICATE;
        end else if (16'(idx_r) >= 16'(e_total)) begin
          rs_status_nxt = ST_BAD_INDEX;
        end else if (size_r != e_size) begin
          rs_status_nxt = ST_SIZE_MISMATCH;
        end else if (cnt_inc != e_total) begin
          mem_wdata     = {1'b1, id_r, e_size, e_total, cnt_inc, e_seen | frag_bit, now_r};
          rs_status_nxt = ST_STORED;
          rs_frag_nxt   = idx_r[FSLOT_W-1:0];
        end else begin
          // Last fragment: report the packet and free the slot.
          mem_wdata     = '0;
          win_complete  = 1'b1;
          rs_status_nxt = ST_COMPLETE;
          rs_frag_nxt   = idx_r[FSLOT_W-1:0];
          rs_id_nxt     = id_r;
          rs_size_nxt   = e_size;
          rs_frags_nxt  = e_total;
        end
      end
      FS_FIN: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = FS_IDLE;
        end
      end
      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FS_CLEAR;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      len_r  <= in_length_ok;
      id_r   <= in_packet_id;
      idx_r  <= in_fragment_index;
      size_r <= in_declared_size;
      now_r  <= in_time_now;
    end
    ra_r         <= ra_nxt;
    found_r      <= found_nxt;
    free_found_r <= free_found_nxt;
    match_r      <= match_nxt;
    free_r       <= free_nxt;
    best_r       <= best_nxt;
    best_stamp_r <= best_stamp_nxt;
    rs_status_r  <= rs_status_nxt;
    rs_slot_r    <= rs_slot_nxt;
    rs_frag_r    <= rs_frag_nxt;
    rs_id_r      <= rs_id_nxt;
    rs_size_r    <= rs_size_nxt;
    rs_frags_r   <= rs_frags_nxt;
    if (load_out) begin
      o_status_r <= rs_status_r;
      o_slot_r   <= rs_slot_r;
      o_frag_r   <= rs_frag_r;
      o_id_r     <= rs_id_r;
      o_size_r   <= rs_size_r;
      o_frags_r  <= rs_frags_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_slot           = o_slot_r;
  assign out_fragment_slot  = o_frag_r;
  assign out_done_id        = o_id_r;
  assign out_done_size      = o_size_r;
  assign out_done_fragments = o_frags_r;

endmodule

/* design/frt_slot_mem.sv */
`timescale 1ns / 1ps

module frt_slot_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/frt_window.sv */
`timescale 1ns / 1ps

module frt_window #(
  parameter int WINDOW = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [frt_pkg::ID_W-1:0] id,
  input  logic                   complete,
  output frt_pkg::frt_win_t      verdict
);
  import frt_pkg::*;

  localparam int MW = 2 * WINDOW + 1;
  localparam int PW = $clog2(MW);
  localparam int AW = $clog2(WINDOW + 1);

  logic [ID_W-1:0] last_r, last_nxt;
  logic [MW-1:0]   map_r, map_nxt;
  logic [ID_W-1:0] ahead, behind;
  logic            ahead_in, behind_in, advance;
  logic [PW-1:0]   pos, mark;
  logic [MW-1:0]   shifted;

  always_comb begin
    ahead     = id - last_r;
    behind    = last_r - id;
    ahead_in  = ahead <= ID_W'(WINDOW);
    behind_in = behind <= ID_W'(WINDOW);
    pos = ahead_in ? PW'(WINDOW) - PW'(ahead[AW-1:0])
                   : PW'(WINDOW) + PW'(behind[AW-1:0]);
    verdict.out_of_window = !ahead_in && !behind_in;
    verdict.replay        = map_r[pos];

    // Completion slides the window forward only for ids ahead of it.
    advance = ahead_in && (ahead != '0);
    shifted = map_r << ahead[AW-1:0];
    mark    = advance ? PW'(WINDOW) : PW'(WINDOW) + PW'(behind[AW-1:0]);
    last_nxt = last_r;
    map_nxt  = map_r;
    if (complete) begin
      if (advance) begin
        last_nxt = id;
        map_nxt  = shifted;
      end
      map_nxt[mark] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      map_r  <= '0;
    end else begin
      last_r <= last_nxt;
      map_r  <= map_nxt;
    end
  end

endmodule
